// ----- src/assert_macros.svh -----
// assertion macros used by the checker file
// depends on nothing; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent assertion on an explicit clock, disabled while reset is low
`define IIDA_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// same, on the usual clock and reset names
`define IIDA_ASSERT_STD(label, prop, msg) \
  `IIDA_ASSERT(label, clk_i, rst_ni, prop, msg)

`endif

// ----- src/iida_pkg.sv -----
// package for the indexed insert/delete array: field widths, codes, states
// depends on nothing
package iida_pkg;

  localparam int REQ_W   = 3;
  localparam int POS_W   = 7;
  localparam int DATA_W  = 32;
  localparam int STAT_W  = 2;
  localparam int COUNT_W = 7;

  // request codes
  typedef enum logic [REQ_W-1:0] {
    REQ_GET    = 3'd0,
    REQ_SET    = 3'd1,
    REQ_INSERT = 3'd2,
    REQ_DELETE = 3'd3,
    REQ_APPEND = 3'd4
  } req_type_e;

  // result status codes
  typedef enum logic [STAT_W-1:0] {
    STAT_DONE  = 2'd0,
    STAT_RANGE = 2'd1,
    STAT_FULL  = 2'd2
  } status_e;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GET,
    ST_UP,
    ST_INS,
    ST_DOWN,
    ST_DONE
  } state_e;

endpackage

// ----- src/iida_req_if.sv -----
// request channel: valid/ready plus request fields
// depends on iida_pkg
interface iida_req_if;
  logic                        valid;
  logic                        ready;
  logic [iida_pkg::REQ_W-1:0]  req_type;
  logic [iida_pkg::POS_W-1:0]  position;
  logic [iida_pkg::DATA_W-1:0] write_value;

  modport source (output valid, output req_type, output position, output write_value,
                  input ready);
  modport sink   (input valid, input req_type, input position, input write_value,
                  output ready);
endinterface

// ----- src/iida_rsp_if.sv -----
// response channel: valid/ready plus result fields
// depends on iida_pkg
interface iida_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [iida_pkg::STAT_W-1:0]  status;
  logic [iida_pkg::DATA_W-1:0]  read_value;
  logic [iida_pkg::COUNT_W-1:0] entry_count;

  modport source (output valid, output status, output read_value, output entry_count,
                  input ready);
  modport sink   (input valid, input status, input read_value, input entry_count,
                  output ready);
endinterface

// ----- src/indexed_insert_delete_array_core.sv -----
// ordered array with get/set/insert/delete/append, entries held in one ram
// depends on iida_pkg, iida_req_if, iida_rsp_if, iida_ram
//
//  channel  dir  carries
//  req_i    in   req_type, position, write_value
//  rsp_o    out  status, read_value, entry_count
//
// one request at a time; get reads the ram and then captures the word.
// insert moves the entries from the top down to the position up one slot,
// then writes the new word; delete moves the entries above the hole down;
// the ram moves one entry per cycle (read one ahead, write the previous one).
// reset clears the length, the sequencer and the output valid flag; ram contents stay undefined.
// a waiting result is held in the output register; the next request is taken
// meanwhile and its result waits in the done state until the output frees up.
module indexed_insert_delete_array_core #(
  parameter int CAPACITY    = 64,
  parameter int ENTRY_WIDTH = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  iida_req_if.sink   req_i,
  iida_rsp_if.source rsp_o
);

  localparam int AW   = $clog2(CAPACITY);
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > iida_pkg::POS_W) ? CW : iida_pkg::POS_W;

  iida_pkg::state_e state_q, state_d;
  logic [CW-1:0]    count_q, count_d;
  logic [AW-1:0]    src_q, src_d;
  logic [AW-1:0]    pos_q, pos_d;
  logic [ENTRY_WIDTH-1:0]       val_q, val_d;
  iida_pkg::status_e            pend_status_q, pend_status_d;
  logic [iida_pkg::DATA_W-1:0]  pend_rd_q, pend_rd_d;
  logic                         out_valid_q, out_valid_d;
  iida_pkg::status_e            out_status_q, out_status_d;
  logic [iida_pkg::DATA_W-1:0]  out_rd_q, out_rd_d;
  logic [iida_pkg::COUNT_W-1:0] out_count_q, out_count_d;

  logic                   ram_we, ram_re;
  logic [AW-1:0]          ram_waddr, ram_raddr;
  logic [ENTRY_WIDTH-1:0] ram_wdata, ram_rdata;

  logic            accept;
  logic [CMPW-1:0] pos_ext, cnt_ext;
  logic [AW-1:0]   pos_a, cnt_a;
  logic            in_range, ins_ok, full;
  logic [ENTRY_WIDTH-1:0] in_val;

  // entry store
  iida_ram #(
    .WIDTH (ENTRY_WIDTH),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // request decode helpers
  assign req_i.ready = (state_q == iida_pkg::ST_IDLE);
  assign accept      = req_i.valid && req_i.ready;
  assign pos_ext     = CMPW'(req_i.position);
  assign cnt_ext     = CMPW'(count_q);
  assign pos_a       = AW'(req_i.position);
  assign cnt_a       = AW'(count_q);
  assign in_range    = pos_ext < cnt_ext;
  assign ins_ok      = pos_ext <= cnt_ext;
  assign full        = (count_q == CW'(CAPACITY));
  assign in_val      = ENTRY_WIDTH'(req_i.write_value);

  // sequencer next state, ram control and result staging
  always_comb begin
    state_d       = state_q;
    count_d       = count_q;
    src_d         = src_q;
    pos_d         = pos_q;
    val_d         = val_q;
    pend_status_d = pend_status_q;
    pend_rd_d     = pend_rd_q;
    out_valid_d   = out_valid_q && !rsp_o.ready;
    out_status_d  = out_status_q;
    out_rd_d      = out_rd_q;
    out_count_d   = out_count_q;
    ram_we        = 1'b0;
    ram_waddr     = pos_a;
    ram_wdata     = in_val;
    ram_re        = 1'b0;
    ram_raddr     = pos_a;

    case (state_q)
      iida_pkg::ST_IDLE: begin
        if (accept) begin
          pend_status_d = iida_pkg::STAT_DONE;
          pend_rd_d     = '0;
          state_d       = iida_pkg::ST_DONE;
          case (iida_pkg::req_type_e'(req_i.req_type))
            iida_pkg::REQ_GET: begin
              if (in_range) begin
                ram_re  = 1'b1;
                state_d = iida_pkg::ST_GET;
              end else begin
                pend_status_d = iida_pkg::STAT_RANGE;
              end
            end
            iida_pkg::REQ_SET: begin
              if (in_range) begin
                ram_we = 1'b1;
              end else begin
                pend_status_d = iida_pkg::STAT_RANGE;
              end
            end
            iida_pkg::REQ_INSERT: begin
              if (!ins_ok) begin
                pend_status_d = iida_pkg::STAT_RANGE;
              end else if (full) begin
                pend_status_d = iida_pkg::STAT_FULL;
              end else begin
                count_d = count_q + CW'(1);
                if (pos_ext == cnt_ext) begin
                  ram_we = 1'b1;
                end else begin
                  // start moving entries up from the top
                  ram_re    = 1'b1;
                  ram_raddr = cnt_a - AW'(1);
                  src_d     = cnt_a - AW'(1);
                  pos_d     = pos_a;
                  val_d     = in_val;
                  state_d   = iida_pkg::ST_UP;
                end
              end
            end
            iida_pkg::REQ_DELETE: begin
              if (!in_range) begin
                pend_status_d = iida_pkg::STAT_RANGE;
              end else begin
                count_d = count_q - CW'(1);
                if ((pos_ext + CMPW'(1)) != cnt_ext) begin
                  // start moving entries down from above the hole
                  ram_re    = 1'b1;
                  ram_raddr = pos_a + AW'(1);
                  src_d     = pos_a + AW'(1);
                  state_d   = iida_pkg::ST_DOWN;
                end
              end
            end
            iida_pkg::REQ_APPEND: begin
              if (full) begin
                pend_status_d = iida_pkg::STAT_FULL;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = cnt_a;
                count_d   = count_q + CW'(1);
              end
            end
            default: begin
            end
          endcase
        end
      end

      // capture the read word
      iida_pkg::ST_GET: begin
        pend_rd_d = iida_pkg::DATA_W'(ram_rdata);
        state_d   = iida_pkg::ST_DONE;
      end

      // shift up: write entry src into src+1, read the one below
      iida_pkg::ST_UP: begin
        ram_we    = 1'b1;
        ram_waddr = src_q + AW'(1);
        ram_wdata = ram_rdata;
        if (src_q == pos_q) begin
          state_d = iida_pkg::ST_INS;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = src_q - AW'(1);
          src_d     = src_q - AW'(1);
        end
      end

      // drop the new word into the opened slot
      iida_pkg::ST_INS: begin
        ram_we    = 1'b1;
        ram_waddr = pos_q;
        ram_wdata = val_q;
        state_d   = iida_pkg::ST_DONE;
      end

      // shift down: write entry src into src-1, read the one above
      iida_pkg::ST_DOWN: begin
        ram_we    = 1'b1;
        ram_waddr = src_q - AW'(1);
        ram_wdata = ram_rdata;
        if (CW'(src_q) == count_q) begin
          state_d = iida_pkg::ST_DONE;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = src_q + AW'(1);
          src_d     = src_q + AW'(1);
        end
      end

      // hand the word to the output register once it is free
      iida_pkg::ST_DONE: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_valid_d  = 1'b1;
          out_status_d = pend_status_q;
          out_rd_d     = pend_rd_q;
          out_count_d  = iida_pkg::COUNT_W'(count_q);
          state_d      = iida_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = iida_pkg::ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= iida_pkg::ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    src_q         <= src_d;
    pos_q         <= pos_d;
    val_q         <= val_d;
    pend_status_q <= pend_status_d;
    pend_rd_q     <= pend_rd_d;
    out_status_q  <= out_status_d;
    out_rd_q      <= out_rd_d;
    out_count_q   <= out_count_d;
  end

  // response port
  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.status      = out_status_q;
  assign rsp_o.read_value  = out_rd_q;
  assign rsp_o.entry_count = out_count_q;

endmodule

// ----- src/iida_ram.sv -----
// generic simple dual-port ram: one write port, one registered read port
// depends on nothing
module iida_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// ----- src/iida_checker.sv -----
// port-level checks for the array core, bound onto the top level
// depends on iida_pkg, assert_macros.svh, indexed_insert_delete_array_core
`include "assert_macros.svh"

module iida_checker #(
  parameter int CAPACITY = 64
) (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         req_valid,
  input logic                         req_ready,
  input logic                         rsp_valid,
  input logic                         rsp_ready,
  input logic [iida_pkg::STAT_W-1:0]  rsp_status,
  input logic [iida_pkg::DATA_W-1:0]  rsp_read_value,
  input logic [iida_pkg::COUNT_W-1:0] rsp_entry_count
);

  localparam logic [iida_pkg::COUNT_W-1:0] CapLow = iida_pkg::COUNT_W'(CAPACITY);

  // a stalled result word holds
  `IIDA_ASSERT_STD(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_read_value) && $stable(rsp_entry_count), "response changed while stalled")

  // one request in flight: ready drops after an accept
  `IIDA_ASSERT_STD(a_one_at_a_time, req_valid && req_ready |=> !req_ready, "request taken while busy")

  // read data only on success
  `IIDA_ASSERT_STD(a_rd_zero, rsp_valid && (rsp_status != iida_pkg::STAT_DONE) |-> rsp_read_value == '0, "read data on failed request")

  // full only reported with the array at capacity
  `IIDA_ASSERT_STD(a_full_count, rsp_valid && (rsp_status == iida_pkg::STAT_FULL) |-> rsp_entry_count == CapLow, "full status below capacity")

  // length never exceeds capacity (checked only for capacities up to 127)
  `IIDA_ASSERT_STD(a_count_bound, rsp_valid |-> (CAPACITY > 127) || (rsp_entry_count <= CapLow), "entry count above capacity")

endmodule

bind indexed_insert_delete_array_core iida_checker #(
  .CAPACITY (CAPACITY)
) u_iida_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .req_valid       (req_i.valid),
  .req_ready       (req_i.ready),
  .rsp_valid       (rsp_o.valid),
  .rsp_ready       (rsp_o.ready),
  .rsp_status      (rsp_o.status),
  .rsp_read_value  (rsp_o.read_value),
  .rsp_entry_count (rsp_o.entry_count)
);
